@@ rtl/rhht_pkg.sv @@
// Shared constants for the Robin Hood hash table core: operation and status
// codes, field widths and parameter defaults. No dependencies.
`timescale 1ns / 1ps
package rhht_pkg;
   localparam int SLOTS_DEFAULT      = 1024;
   localparam int KEY_BITS_DEFAULT   = 64;
   localparam int VALUE_BITS_DEFAULT = 64;

   localparam int OP_W     = 2;
   localparam int KEY_W    = 64;
   localparam int HASH_W   = 32;
   localparam int VALUE_W  = 64;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 10;
   localparam int CAP_W    = 10;

   localparam logic [CAP_W-1:0] CAP_RESET = 10'd921;

   localparam logic [OP_W-1:0] OP_FIND   = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_W-1:0] OP_NEW    = 2'd2;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

   localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
   localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
   localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd5;
endpackage

@@ rtl/rhht_slot_ram.sv @@
// Slot store of the hash table: one row per slot holding hash, key and value.
// One write port and one registered read port. No dependencies.
`timescale 1ns / 1ps
module rhht_slot_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 160
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/robin_hood_hash_table_core.sv @@
// Top level of the Robin Hood hash table: request sequencer, probe logic and
// result register. Depends on rhht_pkg and rhht_slot_ram.
//
// Usage:
//   Requests enter on the req_ channel (op, key, hash, value) and each one
//   yields exactly one word on the rsp_ channel (status, slot, value_res).
//   The csr_ channel writes the capacity limit; it is always ready.
//   One request is worked on at a time. Each probed slot passes through
//   a registered read of the slot row, then the compare and optional swap
//   write. A clear sweeps every slot, one row per cycle.
//   After reset the same sweep runs before the first request is accepted;
//   configuration writes are taken throughout.
//   A new request is accepted as soon as the sequencer is idle, even while
//   the previous result still waits. If the receiver stalls, the sequencer
//   holds its last step, with no table update, until the result register
//   frees up.
`timescale 1ns / 1ps
module robin_hood_hash_table_core #(
   parameter int SLOTS      = rhht_pkg::SLOTS_DEFAULT,
   parameter int KEY_BITS   = rhht_pkg::KEY_BITS_DEFAULT,
   parameter int VALUE_BITS = rhht_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [rhht_pkg::OP_W-1:0]     req_op,
   input  logic [rhht_pkg::KEY_W-1:0]    req_key,
   input  logic [rhht_pkg::HASH_W-1:0]   req_hash,
   input  logic [rhht_pkg::VALUE_W-1:0]  req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rhht_pkg::STATUS_W-1:0] rsp_status,
   output logic [rhht_pkg::SLOT_W-1:0]   rsp_slot,
   output logic [rhht_pkg::VALUE_W-1:0]  rsp_value_res,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rhht_pkg::CAP_W-1:0]    csr_data
);
   localparam int IW = $clog2(SLOTS);
   localparam int CW = IW + 1;
   localparam int MW = (CW > rhht_pkg::CAP_W) ? CW : rhht_pkg::CAP_W;
   localparam int HW = rhht_pkg::HASH_W;
   localparam int RW = HW + KEY_BITS + VALUE_BITS;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_CLR   = 5'b00010,
      S_CDONE = 5'b00100,
      S_RD    = 5'b01000,
      S_EV    = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [rhht_pkg::OP_W-1:0] op_ff, op_in;
   logic [KEY_BITS-1:0]       key_ff, key_in, cur_k_ff, cur_k_in;
   logic [HW-1:0]             hash_ff, hash_in, cur_h_ff, cur_h_in;
   logic [VALUE_BITS-1:0]     val_ff, val_in, cur_v_ff, cur_v_in;
   logic [IW-1:0]             idx_ff, idx_in, placed_ff, placed_in;
   logic [IW-1:0]             clr_ptr_ff, clr_ptr_in, plimit_ff, plimit_in;
   logic [CW-1:0]             dist_ff, dist_in, maxd_ff, maxd_in;
   logic [CW-1:0]             count_ff, count_in;
   logic                      have_ff, have_in;
   logic [rhht_pkg::CAP_W-1:0] cap_ff, cap_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [rhht_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [rhht_pkg::SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [rhht_pkg::VALUE_W-1:0]  rsp_value_ff, rsp_value_in;

   logic          wr_en;
   logic [IW-1:0] wr_addr, rd_addr;
   logic [RW-1:0] wr_data, rd_data;
   logic [HW-1:0] row_h;
   logic [KEY_BITS-1:0]   row_k;
   logic [VALUE_BITS-1:0] row_v;
   logic [IW-1:0] its;
   logic          out_free, full_cond, match, is_ins;

   rhht_slot_ram #(.DEPTH(SLOTS), .WIDTH(RW)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign row_h     = rd_data[RW-1 -: HW];
   assign row_k     = rd_data[VALUE_BITS +: KEY_BITS];
   assign row_v     = rd_data[VALUE_BITS-1:0];
   assign its       = idx_ff - row_h[IW-1:0];
   assign match     = (row_h == hash_ff) && (row_k == key_ff);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign is_ins    = (op_ff == rhht_pkg::OP_INSERT) || (op_ff == rhht_pkg::OP_NEW);
   assign full_cond = (hash_ff == '0) || (MW'(count_ff) >= MW'(cap_ff)) || count_ff[IW];
   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rd_addr   = idx_ff;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      hash_in       = hash_ff;
      val_in        = val_ff;
      cur_h_in      = cur_h_ff;
      cur_k_in      = cur_k_ff;
      cur_v_in      = cur_v_ff;
      idx_in        = idx_ff;
      placed_in     = placed_ff;
      clr_ptr_in    = clr_ptr_ff;
      plimit_in     = plimit_ff;
      dist_in       = dist_ff;
      maxd_in       = maxd_ff;
      count_in      = count_ff;
      have_in       = have_ff;
      cap_in        = csr_valid ? csr_data : cap_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_value_in  = rsp_value_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = {cur_h_ff, cur_k_ff, cur_v_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req_op;
               key_in    = req_key[KEY_BITS-1:0];
               hash_in   = req_hash;
               val_in    = req_value[VALUE_BITS-1:0];
               cur_h_in  = req_hash;
               cur_k_in  = req_key[KEY_BITS-1:0];
               cur_v_in  = req_value[VALUE_BITS-1:0];
               idx_in    = req_hash[IW-1:0];
               dist_in   = '0;
               maxd_in   = CW'(plimit_ff);
               have_in   = 1'b0;
               placed_in = '0;
               if (req_op == rhht_pkg::OP_CLEAR) begin
                  clr_ptr_in = '0;
                  count_in   = '0;
                  plimit_in  = '0;
                  state_in   = S_CLR;
               end else begin
                  state_in = S_RD;
               end
            end
         end
         S_CLR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_ptr_ff;
            wr_data    = '0;
            clr_ptr_in = clr_ptr_ff + 1'b1;
            if (clr_ptr_ff == IW'(SLOTS - 1)) begin
               state_in = (op_ff == rhht_pkg::OP_CLEAR) ? S_CDONE : S_IDLE;
            end
         end
         S_CDONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = rhht_pkg::ST_CLEARED;
               rsp_slot_in   = '0;
               rsp_value_in  = '0;
               state_in      = S_IDLE;
            end
         end
         S_RD: begin
            state_in = S_EV;
         end
         S_EV: begin
            // Each arm that ends the request waits for a free result register
            // and makes no table update until then.
            if (!is_ins) begin
               priority if (hash_ff == '0 || row_h == '0 ||
                            (!match && dist_ff == CW'(plimit_ff))) begin
                  if (out_free) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = rhht_pkg::ST_NOT_FOUND;
                     rsp_slot_in   = '0;
                     rsp_value_in  = '0;
                     state_in      = S_IDLE;
                  end
               end else if (match) begin
                  if (out_free) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = rhht_pkg::ST_FOUND;
                     rsp_slot_in   = rhht_pkg::SLOT_W'(idx_ff);
                     rsp_value_in  = rhht_pkg::VALUE_W'(row_v);
                     state_in      = S_IDLE;
                  end
               end else begin
                  dist_in  = dist_ff + 1'b1;
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_RD;
               end
            end else begin
               priority if (full_cond) begin
                  if (out_free) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = rhht_pkg::ST_FULL;
                     rsp_slot_in   = '0;
                     rsp_value_in  = '0;
                     state_in      = S_IDLE;
                  end
               end else if (row_h == '0) begin
                  if (out_free) begin
                     wr_en         = 1'b1;
                     plimit_in     = (dist_ff > maxd_ff) ? dist_ff[IW-1:0] : maxd_ff[IW-1:0];
                     count_in      = count_ff + 1'b1;
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = rhht_pkg::ST_INSERTED;
                     rsp_slot_in   = rhht_pkg::SLOT_W'(have_ff ? placed_ff : idx_ff);
                     rsp_value_in  = rhht_pkg::VALUE_W'(val_ff);
                     state_in      = S_IDLE;
                  end
               end else if (op_ff == rhht_pkg::OP_INSERT && !have_ff && match) begin
                  if (out_free) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = rhht_pkg::ST_PRESENT;
                     rsp_slot_in   = rhht_pkg::SLOT_W'(idx_ff);
                     rsp_value_in  = rhht_pkg::VALUE_W'(row_v);
                     state_in      = S_IDLE;
                  end
               end else begin
                  if (CW'(its) < dist_ff) begin
                     // The resident sits closer to home: it gives up the slot
                     // and is carried forward instead.
                     wr_en    = 1'b1;
                     cur_h_in = row_h;
                     cur_k_in = row_k;
                     cur_v_in = row_v;
                     if (dist_ff > maxd_ff) begin
                        maxd_in = dist_ff;
                     end
                     dist_in = CW'(its) + 1'b1;
                     if (!have_ff) begin
                        have_in   = 1'b1;
                        placed_in = idx_ff;
                     end
                  end else begin
                     dist_in = dist_ff + 1'b1;
                  end
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         op_ff        <= rhht_pkg::OP_FIND;
         clr_ptr_ff   <= '0;
         count_ff     <= '0;
         plimit_ff    <= '0;
         cap_ff       <= rhht_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         clr_ptr_ff   <= clr_ptr_in;
         count_ff     <= count_in;
         plimit_ff    <= plimit_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      hash_ff       <= hash_in;
      val_ff        <= val_in;
      cur_h_ff      <= cur_h_in;
      cur_k_ff      <= cur_k_in;
      cur_v_ff      <= cur_v_in;
      idx_ff        <= idx_in;
      placed_ff     <= placed_in;
      dist_ff       <= dist_in;
      maxd_ff       <= maxd_in;
      have_ff       <= have_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_slot      = rsp_slot_ff;
   assign rsp_value_res = rsp_value_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff[IW] |-> (count_ff[IW-1:0] == '0))
      else $error("entry count beyond table size");
   a_clear_wipes: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_op == rhht_pkg::OP_CLEAR) |=>
         (count_ff == '0 && plimit_ff == '0))
      else $error("clear did not reset count and probe limit");
   a_sweep_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLR) |-> (!req_ready && wr_en))
      else $error("request accepted or no write during clearing sweep");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff) && $past(state_ff) == S_EV) |->
         (count_ff == $past(count_ff) + 1'b1 && rsp_status_ff == rhht_pkg::ST_INSERTED))
      else $error("entry count changed without an insert");
`endif
endmodule
